@@ src/assert_macros.svh @@
// Assertion helper macros for the windowed integral controller.
// Included by the top level; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked implication, disabled while in reset.
`define WCI_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define WCI_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Implication that is also checked during reset.
`define WCI_ASSERT_ALWAYS(label, clk, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/wci_pkg.sv @@
// Shared constants and register codes for the windowed integral controller.
// No dependencies.
`timescale 1ns / 1ps

package wci_pkg;

  localparam int WINDOW_LEN_DEF = 10;
  localparam int TEMP_W         = 16;
  localparam int ERR_W          = 17;
  localparam int GAIN_W         = 16;
  localparam int CUR_W          = 32;
  localparam int SUM_OUT_W      = 20;

  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  localparam logic signed [TEMP_W-1:0] TARGET_LIMIT = 16'sd6400;
  localparam logic [GAIN_W-1:0]        GAIN_RESET   = 16'd336;
  localparam logic [CUR_W-1:0]         CUR_MAX_RESET = 32'h8000_0000;

  // register indexes (byte address / 4)
  localparam logic [1:0] REG_TARGET   = 2'd0;
  localparam logic [1:0] REG_GAIN     = 2'd1;
  localparam logic [1:0] REG_CUR_MAX  = 2'd2;

endpackage

@@ src/wci_cell.sv @@
// One window cell: holds a single error and passes it on when the row shifts.
// Depends on wci_pkg.
`timescale 1ns / 1ps

module wci_cell
  import wci_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    shift,
  input  logic signed [ERR_W-1:0] din,
  output logic signed [ERR_W-1:0] dout
);

  logic signed [ERR_W-1:0] err;

  always_ff @(posedge clk) begin
    if (rst) begin
      err <= '0;
    end else if (shift) begin
      err <= din;
    end
  end

  assign dout = err;

endmodule

@@ src/wci_current.sv @@
// Current update pipeline: gain * sum product stage, then subtract and
// saturate against the running current. Depends on wci_pkg.
`timescale 1ns / 1ps

module wci_current
  import wci_pkg::*;
#(
  parameter int SUM_W = ERR_W + 4
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic [GAIN_W-1:0]       gain,
  input  logic [CUR_W-1:0]        cur_max,
  input  logic                    up_valid,
  output logic                    up_stall,
  input  logic signed [SUM_W-1:0] up_sum,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [CUR_W-1:0]        drive_current,
  output logic signed [SUM_W-1:0] out_sum
);

  localparam int PROD_W = GAIN_W + 1 + SUM_W;
  localparam int DIFF_W = ((PROD_W > CUR_W + 1) ? PROD_W : CUR_W + 1) + 1;

  logic                     vld2;
  logic signed [PROD_W-1:0] prod2;
  logic signed [SUM_W-1:0]  sum2;
  logic                     vld3;
  logic [CUR_W-1:0]         cur;
  logic signed [SUM_W-1:0]  sum3;
  logic                     en2;
  logic                     en3;
  logic signed [DIFF_W-1:0] diff;
  logic signed [DIFF_W-1:0] lim;
  logic [CUR_W-1:0]         cur_next;

  assign en3      = !vld3 || !out_stall;
  assign en2      = !vld2 || en3;
  assign up_stall = !en2;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld2 <= 1'b0;
    end else if (en2) begin
      vld2 <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en2 && up_valid) begin
      prod2 <= PROD_W'($signed({1'b0, gain})) * PROD_W'(up_sum);
      sum2  <= up_sum;
    end
  end

  // new current = clamp(old - product, 0, cur_max)
  assign diff = DIFF_W'($signed({1'b0, cur})) - DIFF_W'(prod2);
  assign lim  = DIFF_W'($signed({1'b0, cur_max}));

  always_comb begin
    if (diff < 0) begin
      cur_next = '0;
    end else if (diff > lim) begin
      cur_next = cur_max;
    end else begin
      cur_next = diff[CUR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld3 <= 1'b0;
      cur  <= '0;
    end else if (en3) begin
      vld3 <= vld2;
      if (vld2) begin
        cur <= cur_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en3 && vld2) begin
      sum3 <= sum2;
    end
  end

  assign out_valid     = vld3;
  assign drive_current = cur;
  assign out_sum       = sum3;

endmodule

@@ src/windowed_integral_temp_controller.sv @@
// Top level of the windowed integral temperature controller: config regs,
// row of window cells, running sum, current update pipeline.
// Depends on wci_pkg, wci_cell, wci_current and assert_macros.svh.
`timescale 1ns / 1ps

//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+------------------------------
//  input   | in        | in_valid / in_stall    | measured_temp
//  output  | out       | out_valid / out_stall  | drive_current, window_sum
//  config  | in        | APB psel/penable/pready| paddr, pwdata, prdata
//
//  One transaction per cycle is accepted unless a stall backs up; the result
//  passes the sum, product and current registers in turn before out_valid
//  rises. The running current loop (subtract and clamp) sets the rate: one
//  update per cycle unless stalled. Stalls back up stage by stage; empty
//  stages still take data. Synchronous active-high reset clears the window,
//  the sum and the current and loads register defaults; no clearing pass is
//  needed.

`include "assert_macros.svh"

module windowed_integral_temp_controller
  import wci_pkg::*;
#(
  parameter int WINDOW_LEN = WINDOW_LEN_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  // input channel
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic signed [TEMP_W-1:0]    measured_temp,
  // output channel
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [CUR_W-1:0]            drive_current,
  output logic signed [SUM_OUT_W-1:0] window_sum,
  // configuration port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ADDR_W-1:0]           paddr,
  input  logic [DATA_W-1:0]           pwdata,
  output logic [DATA_W-1:0]           prdata,
  output logic                        pready
);

  // Sum of WINDOW_LEN errors needs clog2(WINDOW_LEN) growth bits.
  localparam int SUM_W = ERR_W + $clog2(WINDOW_LEN);
  localparam int EXT_W = (SUM_W > SUM_OUT_W) ? SUM_W : SUM_OUT_W;

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic signed [TEMP_W-1:0] target_temp;
  logic [GAIN_W-1:0]        loop_gain;
  logic [CUR_W-1:0]         current_max;
  logic                     cfg_wr;
  logic [1:0]               reg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      target_temp <= '0;
      loop_gain   <= GAIN_RESET;
      current_max <= CUR_MAX_RESET;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_TARGET:  target_temp <= pwdata[TEMP_W-1:0];
        REG_GAIN:    loop_gain   <= pwdata[GAIN_W-1:0];
        REG_CUR_MAX: current_max <= pwdata[CUR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_TARGET:  prdata = DATA_W'(target_temp);
      REG_GAIN:    prdata = DATA_W'(loop_gain);
      REG_CUR_MAX: prdata = current_max;
      default:     prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------
  // Error: clamped target minus measurement
  // ---------------------------------------------------------------------
  logic signed [TEMP_W-1:0] tgt_clamped;
  logic signed [ERR_W-1:0]  err_new;

  always_comb begin
    if (target_temp < -TARGET_LIMIT) begin
      tgt_clamped = -TARGET_LIMIT;
    end else if (target_temp > TARGET_LIMIT) begin
      tgt_clamped = TARGET_LIMIT;
    end else begin
      tgt_clamped = target_temp;
    end
  end

  assign err_new = ERR_W'(tgt_clamped) - ERR_W'(measured_temp);

  // ---------------------------------------------------------------------
  // Window: a row of cells shifting on each accepted transaction. The last
  // cell holds the error from WINDOW_LEN transactions ago, which leaves the
  // window as the new one enters.
  // ---------------------------------------------------------------------
  logic                    accept;
  logic                    vld1;
  logic                    stall1;
  logic                    en1;
  logic signed [SUM_W-1:0] sum1;
  logic signed [ERR_W-1:0] tap [WINDOW_LEN+1];

  assign en1      = !vld1 || !stall1;
  assign in_stall = !en1;
  assign accept   = in_valid && en1;
  assign tap[0]   = err_new;

  for (genvar i = 0; i < WINDOW_LEN; i++) begin : g_cell
    wci_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .shift(accept),
      .din  (tap[i]),
      .dout (tap[i+1])
    );
  end

  // Running sum stage; adds the new error, drops the oldest.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld1 <= 1'b0;
      sum1 <= '0;
    end else if (en1) begin
      vld1 <= in_valid;
      if (in_valid) begin
        sum1 <= sum1 - SUM_W'(tap[WINDOW_LEN]) + SUM_W'(err_new);
      end
    end
  end

  // ---------------------------------------------------------------------
  // Product and current stages
  // ---------------------------------------------------------------------
  logic signed [SUM_W-1:0] sum_out;
  logic signed [EXT_W-1:0] sum_ext;

  wci_current #(
    .SUM_W(SUM_W)
  ) u_current (
    .clk          (clk),
    .rst          (rst),
    .gain         (loop_gain),
    .cur_max      (current_max),
    .up_valid     (vld1),
    .up_stall     (stall1),
    .up_sum       (sum1),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .drive_current(drive_current),
    .out_sum      (sum_out)
  );

  // Low bits of the exact sum; wraps for long windows.
  assign sum_ext    = EXT_W'(sum_out);
  assign window_sum = sum_ext[SUM_OUT_W-1:0];

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  `WCI_ASSERT_IMPL(a_cur_limit, clk, rst, out_valid, drive_current <= current_max, "current above limit")
  `WCI_ASSERT_NEXT(a_accept_fills, clk, rst, accept, vld1, "accepted transaction lost in sum stage")
  `WCI_ASSERT_ALWAYS(a_reset_empty, clk, rst, !out_valid && !vld1, "pipeline not empty after reset")

endmodule

@@ verif/windowed_integral_temp_controller_test.sv @@
// Self-checking testbench for windowed_integral_temp_controller.
// Carries its own model of the error window, running sum and current update.
// Depends on wci_pkg and the controller RTL only.
`timescale 1ns / 1ps

module windowed_integral_temp_controller_test;
  import wci_pkg::*;

  // Run limits. CYCLE_LIMIT is far beyond the slowest legitimate run and only
  // trips on a hang.
  localparam int CYCLE_LIMIT   = 200000;
  localparam int SETTLE_CYCLES = 10;   // three pipeline stages plus margin
  localparam int PHASE_ITEMS   = 210;
  localparam int BURST_ITEMS   = 40;
  localparam int HOLD_CYCLES   = 150;
  localparam int TGT_CLAMP     = int'(TARGET_LIMIT);

  typedef struct packed {
    logic [CUR_W-1:0]            current;
    logic signed [SUM_OUT_W-1:0] sum;
  } drive_result_t;

  // ---------------------------------------------------------------------------
  // DUT signals
  // ---------------------------------------------------------------------------
  logic                        clk;
  logic                        rst;
  logic                        in_valid;
  logic                        in_stall;
  logic signed [TEMP_W-1:0]    measured_temp;
  logic                        out_valid;
  logic                        out_stall;
  logic [CUR_W-1:0]            drive_current;
  logic signed [SUM_OUT_W-1:0] window_sum;
  logic                        psel;
  logic                        penable;
  logic                        pwrite;
  logic [ADDR_W-1:0]           paddr;
  logic [DATA_W-1:0]           pwdata;
  logic [DATA_W-1:0]           prdata;
  logic                        pready;

  windowed_integral_temp_controller u_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .measured_temp (measured_temp),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .drive_current (drive_current),
    .window_sum    (window_sum),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // ---------------------------------------------------------------------------
  // Controller model: shadow registers plus window/sum/current state
  // ---------------------------------------------------------------------------
  logic signed [TEMP_W-1:0] cfg_target;
  logic [GAIN_W-1:0]        cfg_gain;
  logic [CUR_W-1:0]         cfg_cur_max;

  int               err_hist [WINDOW_LEN_DEF];
  int               hist_pos;
  longint           hist_sum;
  logic [CUR_W-1:0] level_model;

  // Results predicted for accepted input transactions, oldest first.
  drive_result_t pending_drive[$];

  int send_idle_pct;
  int recv_stall_pct;
  int hold_left;       // long receiver hold-off, counted down by the receiver
  int fail_count;
  int cycle_count;

  function automatic void reset_model();
    cfg_target  = '0;
    cfg_gain    = GAIN_RESET;
    cfg_cur_max = CUR_MAX_RESET;
    foreach (err_hist[i]) err_hist[i] = 0;
    hist_pos    = 0;
    hist_sum    = 0;
    level_model = '0;
  endfunction

  // One update step: clamp target, push the error into the window, update the
  // running sum, then move the current against gain*sum and saturate.
  function automatic drive_result_t compute_drive_update(input logic signed [TEMP_W-1:0] temp);
    int            tgt;
    int            err;
    longint        next_level;
    drive_result_t r;
    tgt = int'(cfg_target);
    if (tgt < -TGT_CLAMP) begin
      tgt = -TGT_CLAMP;
    end else if (tgt > TGT_CLAMP) begin
      tgt = TGT_CLAMP;
    end
    err = tgt - int'(temp);
    hist_sum = hist_sum - longint'(err_hist[hist_pos]) + longint'(err);
    err_hist[hist_pos] = err;
    hist_pos = (hist_pos == WINDOW_LEN_DEF - 1) ? 0 : hist_pos + 1;
    next_level = longint'({32'd0, level_model}) - longint'({48'd0, cfg_gain}) * hist_sum;
    if (next_level < 0) begin
      next_level = 0;
    end
    if (next_level > longint'({32'd0, cfg_cur_max})) begin
      next_level = longint'({32'd0, cfg_cur_max});
    end
    level_model = next_level[CUR_W-1:0];
    r.current   = level_model;
    r.sum       = hist_sum[SUM_OUT_W-1:0];
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Clock, cycle limit
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random stall at the configured rate, or a long hold-off burst
  // when the pressure test asks for one.
  // ---------------------------------------------------------------------------
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker: every output transaction is matched against the oldest
  // prediction. Sampled at the rising edge, before the DUT's flops update.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    drive_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_drive.size() == 0) begin
        $error("unexpected result transaction: drive_current %0d window_sum %0d",
               drive_current, window_sum);
        fail_count++;
      end else begin
        want = pending_drive.pop_front();
        if (drive_current !== want.current) begin
          $error("drive_current mismatch: expected %0d, actual %0d", want.current,
                 drive_current);
          fail_count++;
        end
        if (window_sum !== want.sum) begin
          $error("window_sum mismatch: expected %0d, actual %0d", want.sum, window_sum);
          fail_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Shared tasks
  // ---------------------------------------------------------------------------

  // Offer one temperature sample; idle cycles go in front at the sender rate.
  // Returns at the edge where the transaction is accepted.
  task automatic send_temp(input logic signed [TEMP_W-1:0] temp);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid      <= 1'b0;
      measured_temp <= TEMP_W'($urandom);   // junk while idle must be ignored
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    measured_temp <= temp;
    do @(posedge clk); while (in_stall);
    pending_drive.push_back(compute_drive_update(temp));
  endtask

  // Drop valid and wait until every predicted result has come out.
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_drive.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // APB write: setup cycle then access cycle; shadow copy updated on completion.
  task automatic write_reg(input logic [1:0] idx, input logic [DATA_W-1:0] data);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_TARGET:  cfg_target  = data[TEMP_W-1:0];
      REG_GAIN:    cfg_gain    = data[GAIN_W-1:0];
      REG_CUR_MAX: cfg_cur_max = data[CUR_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Mostly samples close to the clamped target so the current stays inside its
  // range and the loop does real work; the rest spans the full 16-bit range.
  function automatic logic signed [TEMP_W-1:0] pick_temp();
    int t;
    if ($urandom_range(0, 99) < 30) begin
      return TEMP_W'($urandom);
    end
    t = int'(cfg_target);
    if (t > TGT_CLAMP) t = TGT_CLAMP;
    if (t < -TGT_CLAMP) t = -TGT_CLAMP;
    t = t + int'($urandom_range(0, 1023)) - 512;
    return t[TEMP_W-1:0];
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset register values, sample extremes and an alternating bit pattern.
  task automatic test_reset_defaults();
    send_temp(16'sh7fff);
    send_temp(-16'sh8000);
    send_temp(16'sh0000);
    send_temp(-16'sh0001);
    send_temp(16'sh5555);
    drain_results();
  endtask

  // Target beyond +/-25 C must clamp; the boundary +/-6401 too.
  task automatic test_target_clamp();
    write_reg(REG_TARGET, 32'h0000_7fff);
    send_temp(16'sh0000);
    drain_results();
    write_reg(REG_TARGET, 32'hffff_8000);
    send_temp(16'sh0000);
    drain_results();
    write_reg(REG_TARGET, 32'd6401);
    send_temp(16'sd6401);
    drain_results();
    write_reg(REG_TARGET, -32'sd6401);
    send_temp(-16'sh8000);
    drain_results();
  endtask

  // Full-scale gain pushes the current to its upper limit; zero gain freezes it.
  task automatic test_gain_extremes();
    write_reg(REG_TARGET, 32'd0);
    write_reg(REG_GAIN, 32'h0000_ffff);
    send_temp(16'sh7fff);
    send_temp(16'sh7fff);
    send_temp(16'sh7fff);
    drain_results();
    write_reg(REG_GAIN, 32'd0);
    send_temp(-16'sh8000);
    send_temp(16'sd100);
    drain_results();
  endtask

  // Saturate at the top, lower the ceiling (stored current clips on the next
  // step), then a zero ceiling that pins the output at zero.
  task automatic test_current_limits();
    write_reg(REG_GAIN, 32'h0000_ffff);
    write_reg(REG_CUR_MAX, 32'h8000_0000);
    send_temp(16'sh7fff);
    send_temp(16'sh7fff);
    drain_results();
    write_reg(REG_CUR_MAX, 32'd1000);
    send_temp(16'sh0000);
    drain_results();
    write_reg(REG_CUR_MAX, 32'd0);
    send_temp(-16'sh8000);
    send_temp(16'sh7fff);
    drain_results();
  endtask

  // Random samples under four idle patterns, new settings for each phase.
  task automatic test_random_phases();
    for (int ph = 0; ph < 4; ph++) begin
      drain_results();
      case ($urandom_range(0, 3))
        0:       write_reg(REG_TARGET, 32'hffff_8000);
        1:       write_reg(REG_TARGET, 32'h0000_7fff);
        default: write_reg(REG_TARGET, 32'($urandom_range(0, 14000)) - 32'd7000);
      endcase
      case ($urandom_range(0, 3))
        0:       write_reg(REG_GAIN, 32'($urandom_range(0, 65535)));
        1:       write_reg(REG_GAIN, 32'(GAIN_RESET));
        default: write_reg(REG_GAIN, 32'($urandom_range(1, 2000)));
      endcase
      if (ph == 3) begin
        write_reg(REG_CUR_MAX, 32'h8000_0000);
      end else begin
        write_reg(REG_CUR_MAX, $urandom_range(0, 32'h8000_0000));
      end
      // idle mix per phase: none, sender only, receiver only, both
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 57; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 57; end
        default: begin send_idle_pct = 33; recv_stall_pct = 33; end
      endcase
      repeat (PHASE_ITEMS) send_temp(pick_temp());
    end
    drain_results();
  endtask

  // Receiver holds off for a long stretch while the sender keeps offering, so
  // the pipeline fills and the input stalls.
  task automatic test_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    write_reg(REG_TARGET, 32'd2560);
    write_reg(REG_GAIN, 32'(GAIN_RESET));
    write_reg(REG_CUR_MAX, 32'h8000_0000);
    hold_left = HOLD_CYCLES;
    repeat (BURST_ITEMS) send_temp(pick_temp());
    recv_stall_pct = 33;
    drain_results();
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst            = 1'b1;
    in_valid       = 1'b0;
    measured_temp  = '0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_left      = 0;
    fail_count     = 0;
    cycle_count    = 0;
    reset_model();

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_target_clamp();
    test_gain_extremes();
    test_current_limits();
    test_random_phases();
    test_backpressure();

    // anything still queued here means a result never showed up
    if (fail_count == 0 && pending_drive.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+src
src/wci_pkg.sv
src/wci_cell.sv
src/wci_current.sv
src/windowed_integral_temp_controller.sv
verif/windowed_integral_temp_controller_test.sv
